// ----- hdl/magic_header_frame_deframer_core_macros.svh -----
// Assertion macros shared by the deframer RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef MAGIC_HEADER_FRAME_DEFRAMER_CORE_MACROS_SVH
`define MAGIC_HEADER_FRAME_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication
`define MHFD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MHFD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mhfd_pkg.sv -----
// Shared types and constants for the magic-header frame deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mhfd_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'h54;
	localparam logic [7:0] SYNC_SECOND = 8'h42;
	localparam int         HDR_BYTES   = 8;
	localparam int         QUEUE_DEPTH = 4;

	localparam logic [2:0] HDR_POS_TYPE   = 3'd0;
	localparam logic [2:0] HDR_POS_FLAGS  = 3'd1;
	localparam logic [2:0] HDR_POS_LEN_LO = 3'd2;
	localparam logic [2:0] HDR_POS_LEN_HI = 3'd3;
	localparam logic [2:0] HDR_POS_SEQ_0  = 3'd4;
	localparam logic [2:0] HDR_POS_SEQ_1  = 3'd5;
	localparam logic [2:0] HDR_POS_SEQ_2  = 3'd6;
	localparam logic [2:0] HDR_POS_LAST   = 3'(HDR_BYTES - 1);

	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_SYNC1 = 4'b0010,
		PH_HDR   = 4'b0100,
		PH_DATA  = 4'b1000
	} phase_t;

	// one deframed result word
	typedef struct packed {
		logic        last;
		logic        has_payload;
		logic [7:0]  payload_byte;
		logic [31:0] sequence_number;
		logic [15:0] payload_length;
		logic [7:0]  frame_flags;
		logic [7:0]  msg_type;
	} res_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ----- hdl/mhfd_front.sv -----
// Front end: sync hunt, header capture and payload classification.
// Depends on mhfd_pkg; pushes result words into mhfd_queue.
`timescale 1ns / 1ps
`default_nettype none

`include "magic_header_frame_deframer_core_macros.svh"

module mhfd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [7:0]      in_byte,
	output logic                 in_ready,
	input  wire mhfd_pkg::q_stat_t q_stat,
	output logic                 push,
	output mhfd_pkg::res_t       push_res
);

	mhfd_pkg::phase_t phase_q, phase_d;
	logic [2:0]  hdr_pos_q, hdr_pos_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  flags_q, flags_d;
	logic [15:0] len_q, len_d;
	logic [31:0] seq_q, seq_d;
	logic [15:0] rem_q, rem_d;
	logic [15:0] rem_m1;
	logic        accept;
	logic        emit;
	logic        emit_has;
	logic        emit_last;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign rem_m1   = rem_q - 16'd1;

	always_comb begin
		phase_d   = phase_q;
		hdr_pos_d = hdr_pos_q;
		type_d    = type_q;
		flags_d   = flags_q;
		len_d     = len_q;
		seq_d     = seq_q;
		rem_d     = rem_q;
		emit      = 1'b0;
		emit_has  = 1'b0;
		emit_last = 1'b0;
		unique case (phase_q)
			mhfd_pkg::PH_HUNT: begin
				if (in_byte == mhfd_pkg::SYNC_FIRST)
					phase_d = mhfd_pkg::PH_SYNC1;
			end
			mhfd_pkg::PH_SYNC1: begin
				if (in_byte == mhfd_pkg::SYNC_SECOND) begin
					phase_d   = mhfd_pkg::PH_HDR;
					hdr_pos_d = '0;
				end else if (in_byte != mhfd_pkg::SYNC_FIRST) begin
					phase_d = mhfd_pkg::PH_HUNT;
				end
			end
			mhfd_pkg::PH_HDR: begin
				unique case (hdr_pos_q)
					mhfd_pkg::HDR_POS_TYPE:   type_d  = in_byte;
					mhfd_pkg::HDR_POS_FLAGS:  flags_d = in_byte;
					mhfd_pkg::HDR_POS_LEN_LO: len_d   = {8'h00, in_byte};
					mhfd_pkg::HDR_POS_LEN_HI: len_d   = len_q | {in_byte, 8'h00};
					mhfd_pkg::HDR_POS_SEQ_0:  seq_d   = {24'h0, in_byte};
					mhfd_pkg::HDR_POS_SEQ_1:  seq_d   = seq_q | {16'h0, in_byte, 8'h00};
					mhfd_pkg::HDR_POS_SEQ_2:  seq_d   = seq_q | {8'h0, in_byte, 16'h0};
					default:                  seq_d   = seq_q | {in_byte, 24'h0};
				endcase
				if (hdr_pos_q != mhfd_pkg::HDR_POS_LAST) begin
					hdr_pos_d = hdr_pos_q + 3'd1;
				end else begin
					hdr_pos_d = '0;
					if (len_d == 16'd0) begin
						// empty frame: one header-only word
						phase_d   = mhfd_pkg::PH_HUNT;
						emit      = 1'b1;
						emit_last = 1'b1;
					end else begin
						rem_d   = len_d;
						phase_d = mhfd_pkg::PH_DATA;
					end
				end
			end
			mhfd_pkg::PH_DATA: begin
				rem_d     = rem_m1;
				emit      = 1'b1;
				emit_has  = 1'b1;
				emit_last = (rem_m1 == 16'd0);
				if (rem_m1 == 16'd0)
					phase_d = mhfd_pkg::PH_HUNT;
			end
			default: phase_d = mhfd_pkg::PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mhfd_pkg::PH_HUNT;
			hdr_pos_q <= '0;
			type_q    <= '0;
			flags_q   <= '0;
			len_q     <= '0;
			seq_q     <= '0;
			rem_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hdr_pos_q <= hdr_pos_d;
			type_q    <= type_d;
			flags_q   <= flags_d;
			len_q     <= len_d;
			seq_q     <= seq_d;
			rem_q     <= rem_d;
		end
	end

	assign push                     = accept && emit;
	assign push_res.msg_type        = type_d;
	assign push_res.frame_flags     = flags_d;
	assign push_res.payload_length  = len_d;
	assign push_res.sequence_number = seq_d;
	assign push_res.payload_byte    = emit_has ? in_byte : 8'h00;
	assign push_res.has_payload     = emit_has;
	assign push_res.last            = emit_last;

	// a word out of header capture is always the lone word of an empty frame
	`MHFD_ASSERT_IMP(a_hdr_word_empty, push && (phase_q == mhfd_pkg::PH_HDR),
		!push_res.has_payload && push_res.last && (push_res.payload_length == 16'd0),
		"header-phase word is not an empty-frame word")

endmodule

`default_nettype wire

// ----- hdl/mhfd_queue.sv -----
// Short result queue between front and back ends.
// Depends on mhfd_pkg for the word and status types.
`timescale 1ns / 1ps
`default_nettype none

`include "magic_header_frame_deframer_core_macros.svh"

module mhfd_queue #(
	parameter int DEPTH = mhfd_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire mhfd_pkg::res_t    push_res,
	input  wire logic              pop,
	output mhfd_pkg::res_t         head_res,
	output mhfd_pkg::q_stat_t      q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mhfd_pkg::res_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head_res     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	`MHFD_ASSERT_IMP(a_no_overflow, push, !q_stat.full || pop, "push into full queue")
	`MHFD_ASSERT_IMP(a_no_underflow, pop, !q_stat.empty, "pop from empty queue")
	`MHFD_ASSERT_NXT(a_push_not_empty, push, !q_stat.empty, "queue empty after push")

endmodule

`default_nettype wire

// ----- hdl/mhfd_back.sv -----
// Back end: drains the queue into the registered output stream.
// Depends on mhfd_pkg for the word and status types.
`timescale 1ns / 1ps
`default_nettype none

module mhfd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mhfd_pkg::q_stat_t q_stat,
	input  wire mhfd_pkg::res_t    head_res,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [71:0]            out_data,
	output logic [0:0]             out_user,
	output logic                   out_last
);

	logic           valid_q;
	mhfd_pkg::res_t res_q;

	// refill the output register whenever it is empty or being taken
	assign pop = !q_stat.empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || out_ready)
			valid_q <= !q_stat.empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= head_res;
	end

	assign out_valid = valid_q;
	assign out_data  = {res_q.payload_byte, res_q.sequence_number, res_q.payload_length,
		res_q.frame_flags, res_q.msg_type};
	assign out_user  = res_q.has_payload;
	assign out_last  = res_q.last;

endmodule

`default_nettype wire

// ----- hdl/magic_header_frame_deframer_core.sv -----
// Top level of the magic-header frame deframer.
// Instantiates mhfd_front, mhfd_queue and mhfd_back; uses mhfd_pkg.
//
// Usage:
//   s_axis carries one received byte per word in s_axis_tdata[7:0].
//   The front end drops bytes until the sync pair 0x54 0x42, captures the
//   8-byte header (type, flags, length LE16, sequence LE32), then marks
//   each of the next 'length' bytes as a payload word. An empty frame
//   gives one header-only word (tuser 0, payload byte 0, tlast 1).
//   m_axis gives one word per payload byte with the header fields
//   attached; tlast marks the final word of a frame.
//   Throughput: one byte per cycle, sustained while the queue has room.
//   Each word passes to m_axis through the queue write and then the
//   output register.
//   When m_axis stalls, the queue (QUEUE_DEPTH words) keeps taking bytes;
//   s_axis_tready drops only once the queue is full. Header and sync
//   bytes produce no word but still wait for queue room.
//   Reset (arst_n low) returns the block to sync hunting and empties the
//   queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module magic_header_frame_deframer_core #(
	parameter int QUEUE_DEPTH = mhfd_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] msg_type, [15:8] frame_flags, [31:16] payload_length,
	// [63:32] sequence_number, [71:64] payload_byte
	output logic [71:0]      m_axis_tdata,
	output logic [0:0]       m_axis_tuser,   // [0] has_payload
	output logic             m_axis_tlast
);

	mhfd_pkg::q_stat_t q_stat;
	mhfd_pkg::res_t    push_res;
	mhfd_pkg::res_t    head_res;
	logic              push;
	logic              pop;
	logic              front_ready;

	// bytes that emit nothing could pass while full, but ready must not
	// depend on tdata; gate on queue room only
	assign s_axis_tready = front_ready;

	mhfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_ready (front_ready),
		.q_stat   (q_stat),
		.push     (push),
		.push_res (push_res)
	);

	mhfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.pop      (pop),
		.head_res (head_res),
		.q_stat   (q_stat)
	);

	mhfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_res  (head_res),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire
